/* hdl/nab_pkg.sv */
`default_nettype none

package nab_pkg;

    localparam int PIX_W          = 24;
    localparam int CH_W           = 8;
    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // Adds floor(p/8) of each channel onto the running sum.
    function automatic pixel_t blur_add(pixel_t acc, pixel_t p);
        pixel_t r;
        r.red   = acc.red   + {3'b000, p.red[CH_W-1:3]};
        r.green = acc.green + {3'b000, p.green[CH_W-1:3]};
        r.blue  = acc.blue  + {3'b000, p.blue[CH_W-1:3]};
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/nab_ram.sv */
`default_nettype none

module nab_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/neighbour_average_blur_3x3.sv */
`default_nettype none

// 3x3 neighbour blur of an RGB raster: each interior channel is the sum of floor(p/8)
// over the eight neighbours (centre excluded); border pixels pass through. One item is
// taken per clock unless the output stalls, set by the single-port-pair line buffer
// RAM (MAX_WIDTH x 48 bits, both previous rows of a column in one word) that each
// item reads and writes back once. The item that completes a window passes stage 1
// and the output register; output pixel k follows input item k + frame_width + 1. After
// the last pixel of a frame, exactly frame_width + 1 flush items (action = 1) drain the
// tail; frame_end marks the last output. Flushes before the frame is complete and
// pixels after it are ignored. Writing frame_width or frame_height restarts the frame.
module neighbour_average_blur_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nab_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [nab_pkg::CH_W-1:0]        s_in_red,
    input  wire logic [nab_pkg::CH_W-1:0]        s_in_green,
    input  wire logic [nab_pkg::CH_W-1:0]        s_in_blue,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [nab_pkg::CH_W-1:0]        m_out_red,
    output logic      [nab_pkg::CH_W-1:0]        m_out_green,
    output logic      [nab_pkg::CH_W-1:0]        m_out_blue,
    output logic                                 m_frame_end
);

    import nab_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WPW = CW + 1;
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int LW  = 2 * PIX_W;
    localparam int FW_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int FH_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    // frame geometry and positions
    logic [WPW-1:0] fw_reg, fw_next;
    logic [RW-1:0]  fh_reg, fh_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;

    logic                      cfg_take;
    logic [FRAME_WIDTH_W-1:0]  cfg_w;
    logic [FRAME_HEIGHT_W-1:0] cfg_h;
    logic                      item_take;
    logic                      input_done;
    logic                      take_process;
    logic                      take_emit;
    logic [WPW-1:0]            col_inc;
    logic [WPW-1:0]            out_col_inc;
    logic [RW-1:0]             out_row_inc;
    logic                      out_border;
    logic                      out_last;
    pixel_t                    take_px;

    // stage 1: line buffer read in flight
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_border_reg;
    logic          s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    pixel_t        s1_px_reg;
    logic          s1_fwd_reg;
    logic [LW-1:0] s1_fwd_data_reg;
    logic          s1_adv;

    logic [LW-1:0] ram_rdata;
    logic [LW-1:0] line_word;
    logic [LW-1:0] line_wdata;
    pixel_t        line_top;
    pixel_t        line_mid;

    pixel_t win_reg [3][3];
    pixel_t nb      [3][3];
    pixel_t blur_sum;
    pixel_t res_px;

    logic   m_valid_reg;
    pixel_t m_px_reg;
    logic   m_last_reg;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign cfg_w     = cfg_data[FRAME_WIDTH_W-1:0];
    assign cfg_h     = cfg_data[FRAME_HEIGHT_W-1:0];

    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign item_take = s_valid && s_ready;

    always_comb begin
        input_done   = in_row_reg >= fh_reg;
        take_process = item_take && (s_action == input_done);
        take_emit    = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
        col_inc      = {1'b0, in_col_reg} + WPW'(1);
        out_col_inc  = {1'b0, out_col_reg} + WPW'(1);
        out_row_inc  = out_row_reg + RW'(1);
        out_border   = (out_col_reg == '0) || (out_col_inc >= fw_reg) ||
                       (out_row_reg == '0) || (out_row_inc >= fh_reg);
        out_last     = (out_col_inc >= fw_reg) && (out_row_inc >= fh_reg);
        take_px      = s_action ? '0 : pixel_t'{s_in_red, s_in_green, s_in_blue};

        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_take) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (cfg_w == '0) begin
                        fw_next = WPW'(1);
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        fw_next = WPW'(MAX_WIDTH);
                    end else begin
                        fw_next = WPW'(cfg_w);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (cfg_h == '0) begin
                        fh_next = RW'(1);
                    end else if (32'(cfg_h) > MAX_HEIGHT) begin
                        fh_next = RW'(MAX_HEIGHT);
                    end else begin
                        fh_next = RW'(cfg_h);
                    end
                end
                default: begin
                end
            endcase
            if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end else if (take_process) begin
            if (col_inc >= fw_reg) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = col_inc[CW-1:0];
            end
            if (take_emit) begin
                if (out_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_inc >= fw_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_inc;
                end else begin
                    out_col_next = out_col_inc[CW-1:0];
                end
            end
        end
    end

    nab_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (line_wdata),
        .rd_en   (take_process),
        .rd_addr (in_col_reg),
        .rd_data (ram_rdata)
    );

    // entry holds {row r-2, row r-1}; forward when the previous item wrote the same column
    always_comb begin
        line_word  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        line_top   = line_word[LW-1:PIX_W];
        line_mid   = line_word[PIX_W-1:0];
        line_wdata = {line_mid, s1_px_reg};
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            nb[r][0] = win_reg[r][1];
            nb[r][1] = win_reg[r][2];
        end
        nb[0][2] = line_top;
        nb[1][2] = line_mid;
        nb[2][2] = s1_px_reg;
        blur_sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r != 1 || c != 1) begin
                    blur_sum = blur_add(blur_sum, nb[r][c]);
                end
            end
        end
        res_px = s1_border_reg ? nb[1][1] : blur_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg       <= WPW'(FW_RST);
            fh_reg       <= RW'(FH_RST);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;

            if (take_process) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        win_reg[r][c] <= nb[r][c];
                    end
                end
            end

            if (s1_adv && s1_emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_process) begin
            s1_emit_reg     <= take_emit;
            s1_border_reg   <= out_border;
            s1_last_reg     <= out_last;
            s1_col_reg      <= in_col_reg;
            s1_px_reg       <= take_px;
            s1_fwd_reg      <= s1_adv && (s1_col_reg == in_col_reg);
            s1_fwd_data_reg <= line_wdata;
        end
        if (s1_adv && s1_emit_reg) begin
            m_px_reg   <= res_px;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_px_reg.red;
    assign m_out_green = m_px_reg.green;
    assign m_out_blue  = m_px_reg.blue;
    assign m_frame_end = m_last_reg;

endmodule

`default_nettype wire
